### sv/rc4_stream_cipher_macros.svh
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Concurrent assertion wrappers on aclk/aresetn, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RC4_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rc4_stream_cipher: assertion failed");
// next-cycle implication
`define RC4_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rc4_stream_cipher: assertion failed");
`else
`define RC4_ASSERT_IMP(label, ante, cons)
`define RC4_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/rc4sc_pkg.sv
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Types and constants shared by the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam int PERM_DEPTH        = 256;
    localparam int BYTE_W            = 8;
    localparam int FUNC_W            = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY     = 2'd0,
        FUNC_DATA    = 2'd1,
        FUNC_DISCARD = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN_J,
        ST_GEN_SWAP,
        ST_GEN_OUT,
        ST_KS_READ,
        ST_KS_J,
        ST_KS_SWAP,
        ST_KS_WRITE
    } state_t;

endpackage

### sv/rc4_stream_cipher.sv
// Data or discard beat: accepted in idle, then GEN_J, GEN_SWAP and GEN_OUT make the
// dependent reads of S[i], S[j] and S[t]; ready returns only after GEN_OUT ends.
// A data result loads into m_tdata as GEN_OUT ends; an untaken result holds the next.
// Key beat: stays idle; tlast adds a schedule of 256 steps, KS_READ to KS_WRITE each.
// Reset: indices and key count clear; the permutation reads as identity through
// per-entry valid flags, so no clearing pass is needed and ready rises at once.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte stream cipher: key load, key schedule and keystream XOR, driven by
// a small sequencer around one permutation RAM and one key RAM.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rc4sc_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_value
    input  logic [rc4sc_pkg::FUNC_W-1:0]  s_tuser,   // [1:0] func
    input  logic                          s_tlast,   // last_key
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rc4sc_pkg::BYTE_W-1:0]  m_tdata    // [7:0] out_byte
);

    import rc4sc_pkg::*;

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int PERM_AW = $clog2(PERM_DEPTH);

    state_t state_reg, state_next;

    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              is_data_reg, is_data_next;
    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [KEY_AW-1:0] kidx_reg, kidx_next;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] out_reg;

    logic              valid_reg [PERM_DEPTH];
    logic              perm_valid_reg;
    logic [PERM_AW-1:0] perm_raddr_reg;

    logic               perm_we;
    logic [PERM_AW-1:0] perm_waddr;
    logic [BYTE_W-1:0]  perm_wdata;
    logic [PERM_AW-1:0] perm_raddr;
    logic [BYTE_W-1:0]  perm_rdata;
    logic [BYTE_W-1:0]  key_rdata;
    logic               key_we;
    logic               valid_clear;
    logic               out_load;

    logic              accept;
    func_t             in_func;
    logic [BYTE_W-1:0] prd;
    logic [BYTE_W-1:0] i_inc;
    logic [BYTE_W-1:0] gen_j;
    logic [BYTE_W-1:0] ks_j;
    logic [BYTE_W-1:0] t_sum;
    logic [BYTE_W-1:0] ks_byte;
    logic              out_free;
    logic [CNT_W-1:0]  key_count_new;
    logic [CNT_W-1:0]  kidx_wide;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_func  = func_t'(s_tuser);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // entry never written since the last identity load reads as its own index
    assign prd   = perm_valid_reg ? perm_rdata : BYTE_W'(perm_raddr_reg);
    assign i_inc = i_reg + BYTE_W'(1);
    assign gen_j = j_reg + prd;
    assign ks_j  = j_reg + prd + key_rdata;
    assign t_sum = si_reg + prd;
    // after the swap S[i]=sj and S[j]=si; the RAM read of t may predate those writes
    assign ks_byte = (t_reg == j_reg) ? si_reg :
                     (t_reg == i_reg) ? sj_reg : prd;

    assign key_we = accept && (in_func == FUNC_KEY) &&
                    (key_count_reg < CNT_W'(MAX_KEY_BYTES));
    assign key_count_new = key_we ? key_count_reg + CNT_W'(1) : key_count_reg;
    assign kidx_wide     = CNT_W'(kidx_reg) + CNT_W'(1);

    rc4sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk   (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (key_count_reg[KEY_AW-1:0]),
        .wdata (s_tdata),
        .raddr (kidx_reg),
        .rdata (key_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_func == FUNC_DATA || in_func == FUNC_DISCARD) begin
                        state_next = ST_GEN_J;
                    end else if (in_func == FUNC_KEY && s_tlast) begin
                        state_next = ST_KS_READ;
                    end
                end
            end
            ST_GEN_J:    state_next = ST_GEN_SWAP;
            ST_GEN_SWAP: state_next = ST_GEN_OUT;
            ST_GEN_OUT: begin
                if (!is_data_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_KS_READ:  state_next = ST_KS_J;
            ST_KS_J:     state_next = ST_KS_SWAP;
            ST_KS_SWAP:  state_next = ST_KS_WRITE;
            ST_KS_WRITE: begin
                state_next = (i_reg == '1) ? ST_IDLE : ST_KS_READ;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        is_data_next   = is_data_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        kidx_next      = kidx_reg;
        perm_we        = 1'b0;
        perm_waddr     = i_reg;
        perm_wdata     = prd;
        perm_raddr     = i_reg;
        valid_clear    = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FUNC_KEY: begin
                            key_count_next = key_count_new;
                            if (s_tlast) begin
                                // reload identity and start the schedule
                                valid_clear    = 1'b1;
                                len_next       = key_count_new;
                                key_count_next = '0;
                                kidx_next      = '0;
                                i_next         = '0;
                                j_next         = '0;
                            end
                        end
                        FUNC_DATA, FUNC_DISCARD: begin
                            i_next       = i_inc;
                            perm_raddr   = i_inc;
                            is_data_next = (in_func == FUNC_DATA);
                            data_next    = s_tdata;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_GEN_J: begin
                perm_raddr = gen_j;
                j_next     = gen_j;
                si_next    = prd;
            end
            ST_GEN_SWAP: begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = prd;
                perm_raddr = t_sum;
                t_next     = t_sum;
                sj_next    = prd;
            end
            ST_GEN_OUT: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                // hold the read of t while the result waits
                perm_raddr = t_reg;
                out_load   = is_data_reg && out_free;
            end
            ST_KS_READ: begin
                perm_raddr = i_reg;
            end
            ST_KS_J: begin
                perm_raddr = ks_j;
                j_next     = ks_j;
                si_next    = prd;
            end
            ST_KS_SWAP: begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = prd;
            end
            ST_KS_WRITE: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                i_next     = i_inc;
                kidx_next  = (kidx_wide == len_reg) ? '0 : kidx_reg + KEY_AW'(1);
                if (i_reg == '1) begin
                    j_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            len_reg       <= '0;
            kidx_reg      <= '0;
            is_data_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            len_reg       <= len_next;
            kidx_reg      <= kidx_next;
            is_data_reg   <= is_data_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        si_reg         <= si_next;
        sj_reg         <= sj_next;
        t_reg          <= t_next;
        data_reg       <= data_next;
        perm_raddr_reg <= perm_raddr;
        if (out_load) begin
            out_reg <= data_reg ^ ks_byte;
        end
    end

    // valid flags: cleared on reset and at each key schedule, set on write
    always_ff @(posedge aclk) begin
        if (!aresetn || valid_clear) begin
            for (int k = 0; k < PERM_DEPTH; k++) begin
                valid_reg[k] <= 1'b0;
            end
            perm_valid_reg <= 1'b0;
        end else begin
            if (perm_we) begin
                valid_reg[perm_waddr] <= 1'b1;
            end
            perm_valid_reg <= valid_reg[perm_raddr];
        end
    end

    `RC4_ASSERT_IMP(a_key_count_bound, 1'b1, key_count_reg <= CNT_W'(MAX_KEY_BYTES))
    `RC4_ASSERT_IMP(a_len_ok, state_reg == ST_KS_READ, CNT_W'(kidx_reg) < len_reg)
    `RC4_ASSERT_NXT(a_sched_idle, state_reg == ST_KS_WRITE && i_reg == '1, state_reg == ST_IDLE)
    `RC4_ASSERT_NXT(a_sched_clr, state_reg == ST_KS_WRITE && i_reg == '1, (i_reg | j_reg) == '0)
    `RC4_ASSERT_IMP(a_result_source, $rose(m_tvalid_reg), $past(state_reg) == ST_GEN_OUT)

endmodule

### sv/rc4sc_ram.sv
// ----------------------------------------------------------------------------
// rc4sc_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rc4sc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### dv/rc4_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Drives key, data, discard and unused-selector beats into the cipher. A
// software RC4 predictor follows every accepted beat, and each output beat is
// compared with the oldest predicted ciphertext byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4sc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int KEY_DEPTH   = MAX_KEY_BYTES_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 1200;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] val;
        logic              last;
    } rc4_beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;

    rc4_stream_cipher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [BYTE_W-1:0] sbox [PERM_DEPTH];
    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
    int unsigned       key_len;
    logic [BYTE_W-1:0] idx_i;
    logic [BYTE_W-1:0] idx_j;

    rc4_beat_t         pending_beats [$];
    logic [BYTE_W-1:0] cipher_exp_q [$];
    rc4_beat_t         drv_beat;
    int unsigned       total_beats = 0;
    int unsigned       n_accepted = 0;
    int unsigned       n_errors = 0;
    int unsigned       cycle_cnt = 0;
    int unsigned       hold_left = 0;
    bit                hold_done = 1'b0;
    logic              in_fire = 1'b0;

    function automatic void sbox_swap(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        t = sbox[a];
        sbox[a] = sbox[b];
        sbox[b] = t;
    endfunction

    function automatic void sbox_identity();
        for (int k = 0; k < PERM_DEPTH; k++) sbox[k[BYTE_W-1:0]] = k[BYTE_W-1:0];
    endfunction

    function automatic void key_schedule();
        int unsigned       len;
        int unsigned       kpos;
        logic [BYTE_W-1:0] jj;
        len = (key_len == 0) ? 1 : key_len;
        jj = '0;
        sbox_identity();
        for (int k = 0; k < PERM_DEPTH; k++) begin
            kpos = k % len;
            jj = jj + sbox[k[BYTE_W-1:0]] + key_mem[kpos[BYTE_W-1:0]];
            sbox_swap(k[BYTE_W-1:0], jj);
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    function automatic logic [BYTE_W-1:0] ks_next();
        logic [BYTE_W-1:0] sum;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        sbox_swap(idx_i, idx_j);
        sum = sbox[idx_i] + sbox[idx_j];
        return sbox[sum];
    endfunction

    function automatic void cipher_apply(input rc4_beat_t b);
        logic [BYTE_W-1:0] ks;
        case (b.func)
            FUNC_KEY: begin
                if (key_len < KEY_DEPTH) begin
                    key_mem[key_len[BYTE_W-1:0]] = b.val;
                    key_len++;
                end
                if (b.last) begin
                    key_schedule();
                    key_len = 0;
                end
            end
            FUNC_DATA: begin
                ks = ks_next();
                cipher_exp_q.push_back(b.val ^ ks);
            end
            FUNC_DISCARD: begin
                ks = ks_next();
            end
            default: ;
        endcase
    endfunction

    // idle percentage per side, by how far the input stream has progressed
    function automatic int unsigned idle_pct(input bit sender);
        if (n_accepted < total_beats / 3) return sender ? 32 : 61;
        if (n_accepted < (2 * total_beats) / 3) return sender ? 61 : 32;
        return 0;
    endfunction

    // ------------------------------------------------------------------ driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_beats.size() > 0 && $urandom_range(99, 0) >= idle_pct(1'b1)) begin
                drv_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_beat.func;
                s_tdata  <= drv_beat.val;
                s_tlast  <= drv_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= idle_pct(1'b0));
        end
    end

    // ----------------------------------------------------------------- monitor
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_exp_q.size() == 0) begin
                $display("%0t: unexpected output beat: expected none, got %02h",
                         $time, m_tdata);
                n_errors++;
            end else if (cipher_exp_q[0] !== m_tdata) begin
                $display("%0t: out_byte mismatch: expected %02h, got %02h",
                         $time, cipher_exp_q[0], m_tdata);
                n_errors++;
                void'(cipher_exp_q.pop_front());
            end else begin
                void'(cipher_exp_q.pop_front());
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            cipher_apply('{func: s_tuser, val: s_tdata, last: s_tlast});
            n_accepted++;
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_beat(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] v,
                             input logic l);
        pending_beats.push_back('{func: f, val: v, last: l});
    endtask

    task automatic push_key(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            push_beat(FUNC_KEY, BYTE_W'($urandom_range(255, 0)), k == len - 1);
    endtask

    // mostly data beats, some discards, random tlast on both
    task automatic push_stream(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            push_beat(($urandom_range(99, 0) < 15) ? FUNC_DISCARD : FUNC_DATA,
                      BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        int unsigned pick;
        bit          long_done;

        sbox_identity();
        key_len = 0;
        idx_i = '0;
        idx_j = '0;
        long_done = 1'b0;

        // no key loaded yet: identity permutation
        push_beat(FUNC_DATA, 8'h00, 1'b0);
        push_beat(FUNC_DATA, 8'hFF, 1'b1);
        push_beat(FUNC_DISCARD, 8'hFF, 1'b1);
        push_beat(FUNC_DATA, 8'h5A, 1'b0);
        // unused selector does nothing
        push_beat(FUNC_UNUSED, 8'hFF, 1'b1);
        push_beat(FUNC_DATA, 8'hA5, 1'b0);
        // single-byte key
        push_beat(FUNC_KEY, 8'hFF, 1'b1);
        push_beat(FUNC_DATA, 8'h00, 1'b0);
        push_beat(FUNC_DATA, 8'hFF, 1'b0);
        // data and discard in the middle of loading a key
        push_beat(FUNC_KEY, 8'h01, 1'b0);
        push_beat(FUNC_KEY, 8'h80, 1'b0);
        push_beat(FUNC_DATA, 8'hAA, 1'b1);
        push_beat(FUNC_DISCARD, 8'h00, 1'b0);
        push_beat(FUNC_UNUSED, 8'h00, 1'b0);
        push_beat(FUNC_KEY, 8'h00, 1'b1);
        push_beat(FUNC_DATA, 8'h00, 1'b0);
        push_beat(FUNC_DATA, 8'hFF, 1'b1);
        push_beat(FUNC_DISCARD, 8'h55, 1'b0);
        push_beat(FUNC_DATA, 8'h3C, 1'b0);
        push_beat(FUNC_DATA, 8'hC3, 1'b1);

        while (pending_beats.size() < 870) begin
            pick = $urandom_range(99, 0);
            if (!long_done && pending_beats.size() > 400) begin
                // key longer than the store: extra bytes dropped, tlast still honored
                long_done = 1'b1;
                push_key(KEY_DEPTH + 2);
                push_stream($urandom_range(40, 8));
            end else if (pick < 80) begin
                push_key($urandom_range(16, 1));
                push_stream($urandom_range(40, 8));
            end else if (pick < 90) begin
                push_stream($urandom_range(20, 3));
            end else begin
                repeat ($urandom_range(6, 1))
                    push_beat(FUNC_W'($urandom_range(3, 0)), BYTE_W'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)));
            end
        end
        total_beats = pending_beats.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (n_accepted < total_beats) @(posedge aclk);
        while (cipher_exp_q.size() > 0) @(posedge aclk);
        // cover a key schedule still running after the last beat
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (n_errors == 0 && cipher_exp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
